[sv/bcd_display_register_writer_defines.svh]
// Assertion macros for the display register writer RTL.
`ifndef BCD_DISPLAY_REGISTER_WRITER_DEFINES_SVH
`define BCD_DISPLAY_REGISTER_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold outside reset.
`define BCDW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define BCDW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define BCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCDW_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define BCDW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define BCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/bcdw_pkg.sv]
// Types and constants shared by the display register writer modules.
`default_nettype none

package bcdw_pkg;

    localparam int NUM_DIGITS          = 4;
    localparam int WRITES_PER_ITEM     = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [5:0]  ATTR_BASE_ADDR  = 6'h23;
    localparam logic [5:0]  DIGIT_BASE_ADDR = 6'h2B;
    localparam logic [7:0]  ATTR_VALUE      = 8'h20;
    localparam logic [7:0]  POINT_BIT       = 8'h80;
    localparam logic [15:0] RADIX           = 16'd10;
    localparam logic [15:0] DIV10_RECIP     = 16'd52429;
    localparam int          DIV10_SHIFT     = 19;

    typedef struct packed {
        logic [15:0] number;
        logic [7:0]  mask;
    } req_t;

    typedef struct packed {
        logic [5:0] reg_address;
        logic [7:0] reg_data;
        logic       last_write;
    } wr_t;

    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;
        logic [7:0]                 mask;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_xfer_t;

endpackage

`default_nettype wire

[sv/bcdw_front.sv]
// Front end: accepts numbers and splits them into decimal digits over four stages.
`default_nettype none

module bcdw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire bcdw_pkg::req_t   req,
    input  wire logic             q_full,
    output bcdw_pkg::q_xfer_t     push
);
    import bcdw_pkg::*;

    logic [NUM_DIGITS-1:0]              valid_reg;
    logic [NUM_DIGITS-1:0]              valid_next;
    logic [15:0]                        val_reg  [NUM_DIGITS];
    logic [15:0]                        val_next [NUM_DIGITS];
    logic [7:0]                         mask_reg [NUM_DIGITS];
    logic [7:0]                         mask_next[NUM_DIGITS];
    logic [NUM_DIGITS-1:0][3:0]         dig_reg  [NUM_DIGITS];
    logic [NUM_DIGITS-1:0][3:0]         dig_next [NUM_DIGITS];
    logic                               en;

    function automatic logic [15:0] div10(input logic [15:0] v);
        logic [31:0] prod;
        prod = 32'(v) * 32'(DIV10_RECIP);
        return 16'(prod >> DIV10_SHIFT);
    endfunction

    assign en        = !(valid_reg[NUM_DIGITS-1] && q_full);
    assign req_stall = !en;

    always_comb
    begin
        logic [15:0] src_val;
        logic [15:0] q;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (k == 0)
            begin
                src_val      = req.number;
                mask_next[k] = req.mask;
                dig_next[k]  = '0;
                valid_next[k] = req_valid;
            end
            else
            begin
                src_val       = val_reg[k-1];
                mask_next[k]  = mask_reg[k-1];
                dig_next[k]   = dig_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
            q              = div10(src_val);
            val_next[k]    = q;
            dig_next[k][k] = 4'(src_val - q * RADIX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                val_reg[k]  <= val_next[k];
                mask_reg[k] <= mask_next[k];
                dig_reg[k]  <= dig_next[k];
            end
        end
    end

    assign push.valid        = valid_reg[NUM_DIGITS-1] && !q_full;
    assign push.entry.digits = dig_reg[NUM_DIGITS-1];
    assign push.entry.mask   = mask_reg[NUM_DIGITS-1];

endmodule

`default_nettype wire

[sv/bcdw_fifo.sv]
// Short queue of digit entries between the front end and the write sequencer.
`default_nettype none

`include "bcd_display_register_writer_defines.svh"

module bcdw_fifo #(
    parameter int DEPTH = bcdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcdw_pkg::q_xfer_t push,
    output logic                   full,
    output bcdw_pkg::q_xfer_t      head,
    input  wire logic              pop
);
    import bcdw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    `BCDW_ASSERT_NEVER(a_push_full, clk, rst_n, push.valid && full, "push into full queue")
    `BCDW_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !head.valid, "pop from empty queue")
    `BCDW_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CW'(DEPTH), "queue count overflow")
    `BCDW_ASSERT_NEXT(a_count_inc, clk, rst_n, push.valid && !pop, count_reg == $past(count_reg) + CW'(1), "queue count did not grow on push")

endmodule

`default_nettype wire

[sv/bcdw_back.sv]
// Write sequencer: turns each queued entry into eight register writes.
`default_nettype none

module bcdw_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcdw_pkg::q_xfer_t head,
    output logic                   pop,
    output logic                   wr_valid,
    input  wire logic              wr_stall,
    output bcdw_pkg::wr_t          wr
);
    import bcdw_pkg::*;

    localparam int IW = $clog2(WRITES_PER_ITEM);

    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          wr_valid_reg;
    logic          wr_valid_next;
    wr_t           wr_reg;
    wr_t           wr_next;
    logic          load;
    logic          step;
    logic [1:0]    sub;

    assign load = !wr_valid_reg || !wr_stall;
    assign step = load && head.valid;
    assign pop  = step && (idx_reg == IW'(WRITES_PER_ITEM - 1));
    assign sub  = idx_reg[1:0];

    always_comb
    begin
        idx_next      = idx_reg;
        wr_valid_next = wr_valid_reg;
        if (load)
        begin
            wr_valid_next = head.valid;
        end
        if (pop)
        begin
            idx_next = '0;
        end
        else if (step)
        begin
            idx_next = idx_reg + IW'(1);
        end

        wr_next.last_write = (idx_reg == IW'(WRITES_PER_ITEM - 1));
        if (!idx_reg[2])
        begin
            wr_next.reg_address = ATTR_BASE_ADDR - 6'(sub);
            wr_next.reg_data    = head.entry.mask[sub] ? ATTR_VALUE : 8'h00;
        end
        else
        begin
            wr_next.reg_address = DIGIT_BASE_ADDR - 6'(sub);
            wr_next.reg_data    = 8'(head.entry.digits[sub])
                                | (head.entry.mask[{1'b1, sub}] ? POINT_BIT : 8'h00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            wr_reg <= wr_next;
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

`default_nettype wire

[sv/bcd_display_register_writer.sv]
// The first register write of a number passes the four digit stages, the queue and the
// output register. Throughput: one register write per cycle while wr_stall is low, set
// by the write sequencer; the digit pipeline and queue accept a number per cycle until full.
// Reset clears the pipeline valid bits, the queue pointers and the output register valid;
// there is no clearing pass and the block is ready as soon as reset is released.
`default_nettype none

module bcd_display_register_writer #(
    parameter int QUEUE_DEPTH = bcdw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bcdw_pkg::req_t req,
    output logic                wr_valid,
    input  wire logic           wr_stall,
    output bcdw_pkg::wr_t       wr
);
    import bcdw_pkg::*;

    q_xfer_t push;
    q_xfer_t head;
    logic    q_full;
    logic    pop;

    bcdw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .push      (push)
    );

    bcdw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    bcdw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr       (wr)
    );

endmodule

`default_nettype wire
